// ===== design/sam_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sam_pkg;

	typedef enum logic [2:0] {
		OP_ALLOC    = 3'd0,
		OP_ALLOC_AT = 3'd1,
		OP_FREE     = 3'd2,
		OP_LOOKUP   = 3'd3,
		OP_NEXT     = 3'd4,
		OP_CLEAR    = 3'd5
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_RD,
		ST_CHK,
		ST_SHR_RD,
		ST_SHR_CHK,
		ST_CLR
	} state_t;

	localparam logic [2:0] STAT_OK   = 3'd0;
	localparam logic [2:0] STAT_FULL = 3'd1;
	localparam logic [2:0] STAT_OCC  = 3'd2;
	localparam logic [2:0] STAT_BAD  = 3'd3;
	localparam logic [2:0] STAT_END  = 3'd4;

	localparam logic [15:0] SALT_BASE = 16'h8000;

	localparam logic REG_MAX_SLOTS = 1'b0;
	localparam logic REG_SALT_SEED = 1'b1;

	localparam logic [10:0] MAX_SLOTS_RESET = 11'd1024;

endpackage

`default_nettype wire

// ===== design/sam_slot_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sam_slot_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== design/sam_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sam_engine #(
	parameter int SLOT_DEPTH = 1024,
	parameter int AW         = 10,
	parameter int CW         = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic [10:0]   max_slots,
	input  wire logic [15:0]   salt_seed,
	input  wire logic          start,
	output logic               busy,
	input  wire logic [2:0]    opcode,
	input  wire logic [15:0]   slot_index,
	input  wire logic [15:0]   handle_salt,
	output logic               done,
	output logic      [2:0]    status,
	output logic      [9:0]    result_slot,
	output logic      [15:0]   result_salt,
	output logic      [10:0]   live_total,
	output logic      [10:0]   high_water_out,
	output logic               mem_we,
	output logic      [AW-1:0] mem_waddr,
	output logic      [15:0]   mem_wdata,
	output logic      [AW-1:0] mem_raddr,
	input  wire logic [15:0]   mem_rdata
);

	sam_pkg::state_t state_q, state_d;
	sam_pkg::op_t    op_q;
	logic [15:0]     salt_q;
	logic [CW-1:0]   ptr_q, hw_q, live_q, hint_q;
	logic [15:0]     roll_q;
	logic            done_q;
	logic [2:0]      status_q;
	logic [9:0]      rslot_q;
	logic [15:0]     rsalt_q;

	logic [16:0]   limit17, ptr17, hw17, idx17, start17, maxs17;
	logic          idx_neg;
	logic [CW-1:0] hw_m1, ptr_p1;
	logic [15:0]   roll_p1;
	logic          finish, load_res, free_ok, sweep_end;
	logic [2:0]    status_d;
	logic [9:0]    rslot_d;
	logic [15:0]   rsalt_d;

	assign maxs17  = {6'd0, max_slots};
	assign limit17 = (maxs17 < 17'(SLOT_DEPTH)) ? maxs17 : 17'(SLOT_DEPTH);
	assign ptr17   = 17'(ptr_q);
	assign hw17    = 17'(hw_q);
	assign idx_neg = slot_index[15];
	assign idx17   = {1'b0, slot_index};
	assign start17 = {slot_index[15], slot_index} + 17'd1;
	assign hw_m1   = hw_q - 1'b1;
	assign ptr_p1  = ptr_q + 1'b1;
	assign roll_p1 = roll_q + 16'd1;
	assign free_ok = (mem_rdata != 16'd0) && (mem_rdata == salt_q);
	assign sweep_end = (ptr_q == CW'(SLOT_DEPTH - 1));

	assign mem_raddr = (state_q == sam_pkg::ST_SHR_RD) ? hw_m1[AW-1:0] : ptr_q[AW-1:0];
	assign mem_waddr = ptr_q[AW-1:0];

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wdata = 16'd0;
		status_d  = sam_pkg::STAT_OK;
		rslot_d   = 10'd0;
		rsalt_d   = 16'd0;
		load_res  = 1'b0;
		unique case (state_q)
			sam_pkg::ST_INIT: begin
				mem_we = 1'b1;
				if (sweep_end) state_d = sam_pkg::ST_IDLE;
			end
			sam_pkg::ST_CLR: begin
				mem_we = 1'b1;
				if (sweep_end) state_d = sam_pkg::ST_IDLE;
			end
			sam_pkg::ST_IDLE: begin
				if (start) begin
					case (opcode)
						sam_pkg::OP_ALLOC: state_d = sam_pkg::ST_RD;
						sam_pkg::OP_ALLOC_AT: begin
							if (idx_neg || idx17 >= limit17 || handle_salt == 16'd0)
								status_d = sam_pkg::STAT_BAD;
							else
								state_d = sam_pkg::ST_RD;
						end
						sam_pkg::OP_FREE: begin
							if (idx_neg || idx17 >= hw17) status_d = sam_pkg::STAT_BAD;
							else state_d = sam_pkg::ST_RD;
						end
						sam_pkg::OP_LOOKUP: begin
							if (idx_neg || idx17 >= limit17) status_d = sam_pkg::STAT_BAD;
							else state_d = sam_pkg::ST_RD;
						end
						sam_pkg::OP_NEXT: begin
							if (start17[16] || start17 >= hw17) status_d = sam_pkg::STAT_END;
							else state_d = sam_pkg::ST_RD;
						end
						sam_pkg::OP_CLEAR: state_d = sam_pkg::ST_CLR;
						default: state_d = sam_pkg::ST_IDLE;
					endcase
				end
			end
			sam_pkg::ST_RD: begin
				state_d = sam_pkg::ST_CHK;
				if (op_q == sam_pkg::OP_ALLOC && ptr17 >= limit17) begin
					state_d  = sam_pkg::ST_IDLE;
					status_d = sam_pkg::STAT_FULL;
				end else if (op_q == sam_pkg::OP_NEXT && ptr17 >= hw17) begin
					state_d  = sam_pkg::ST_IDLE;
					status_d = sam_pkg::STAT_END;
				end
			end
			sam_pkg::ST_CHK: begin
				state_d = sam_pkg::ST_IDLE;
				case (op_q)
					sam_pkg::OP_ALLOC: begin
						if (mem_rdata == 16'd0) begin
							mem_we    = 1'b1;
							mem_wdata = roll_q;
							rslot_d   = 10'(ptr_q);
							rsalt_d   = roll_q;
						end else begin
							state_d = sam_pkg::ST_RD;
						end
					end
					sam_pkg::OP_ALLOC_AT: begin
						if (mem_rdata != 16'd0) begin
							status_d = sam_pkg::STAT_OCC;
						end else begin
							mem_we    = 1'b1;
							mem_wdata = salt_q;
							rslot_d   = 10'(ptr_q);
							rsalt_d   = salt_q;
						end
					end
					sam_pkg::OP_FREE: begin
						if (!free_ok) begin
							status_d = sam_pkg::STAT_BAD;
						end else begin
							mem_we   = 1'b1;
							rslot_d  = 10'(ptr_q);
							rsalt_d  = salt_q;
							load_res = 1'b1;
							if (ptr_p1 == hw_q) state_d = sam_pkg::ST_SHR_RD;
						end
					end
					sam_pkg::OP_LOOKUP: begin
						if (mem_rdata == 16'd0 || (salt_q != 16'd0 && mem_rdata != salt_q)) begin
							status_d = sam_pkg::STAT_BAD;
						end else begin
							rslot_d = 10'(ptr_q);
							rsalt_d = mem_rdata;
						end
					end
					sam_pkg::OP_NEXT: begin
						if (mem_rdata != 16'd0) begin
							rslot_d = 10'(ptr_q);
							rsalt_d = mem_rdata;
						end else begin
							state_d = sam_pkg::ST_RD;
						end
					end
					default: state_d = sam_pkg::ST_IDLE;
				endcase
			end
			sam_pkg::ST_SHR_RD: begin
				state_d = (hw_q == '0) ? sam_pkg::ST_IDLE : sam_pkg::ST_SHR_CHK;
			end
			sam_pkg::ST_SHR_CHK: begin
				state_d = (mem_rdata == 16'd0) ? sam_pkg::ST_SHR_RD : sam_pkg::ST_IDLE;
			end
			default: state_d = sam_pkg::ST_IDLE;
		endcase
		finish = (state_d == sam_pkg::ST_IDLE) && (state_q != sam_pkg::ST_INIT)
			&& ((state_q != sam_pkg::ST_IDLE) || start);
		if (finish && state_q != sam_pkg::ST_SHR_RD && state_q != sam_pkg::ST_SHR_CHK)
			load_res = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sam_pkg::ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			ptr_q  <= '0;
			hw_q   <= '0;
			live_q <= '0;
			hint_q <= '0;
			roll_q <= sam_pkg::SALT_BASE;
			op_q   <= sam_pkg::OP_ALLOC;
		end else begin
			done_q <= finish;
			case (state_q)
				sam_pkg::ST_INIT: begin
					ptr_q <= ptr_p1;
				end
				sam_pkg::ST_CLR: begin
					ptr_q <= ptr_p1;
					if (sweep_end) begin
						hw_q   <= '0;
						live_q <= '0;
						hint_q <= '0;
						roll_q <= salt_seed | sam_pkg::SALT_BASE;
					end
				end
				sam_pkg::ST_IDLE: begin
					if (start) begin
						op_q <= sam_pkg::op_t'(opcode);
						case (opcode)
							sam_pkg::OP_ALLOC: ptr_q <= hint_q;
							sam_pkg::OP_NEXT:  ptr_q <= CW'(start17);
							sam_pkg::OP_CLEAR: ptr_q <= '0;
							default:           ptr_q <= CW'(idx17);
						endcase
					end
				end
				sam_pkg::ST_CHK: begin
					case (op_q)
						sam_pkg::OP_ALLOC: begin
							if (mem_rdata == 16'd0) begin
								live_q <= live_q + 1'b1;
								if (ptr_q >= hw_q) hw_q <= ptr_p1;
								hint_q <= ptr_p1;
								roll_q <= (roll_p1 == 16'd0) ? sam_pkg::SALT_BASE : roll_p1;
							end else begin
								ptr_q <= ptr_p1;
							end
						end
						sam_pkg::OP_ALLOC_AT: begin
							if (mem_rdata == 16'd0) begin
								live_q <= live_q + 1'b1;
								if (ptr_q >= hw_q) hw_q <= ptr_p1;
								roll_q <= (roll_p1 == 16'hFFFF || roll_p1 == 16'd0)
									? sam_pkg::SALT_BASE : roll_p1;
							end
						end
						sam_pkg::OP_FREE: begin
							if (free_ok) begin
								if (live_q != '0) live_q <= live_q - 1'b1;
								if (ptr_q < hint_q) hint_q <= ptr_q;
								if (ptr_p1 == hw_q) hw_q <= ptr_q;
							end
						end
						sam_pkg::OP_NEXT: begin
							if (mem_rdata == 16'd0) ptr_q <= ptr_p1;
						end
						default: begin
						end
					endcase
				end
				sam_pkg::ST_SHR_CHK: begin
					if (mem_rdata == 16'd0) hw_q <= hw_m1;
				end
				default: begin
				end
			endcase
		end
	end

	// salt of the handle under work; payload only
	always_ff @(posedge clk) begin
		if (state_q == sam_pkg::ST_IDLE && start) salt_q <= handle_salt;
		if (load_res) begin
			status_q <= status_d;
			rslot_q  <= rslot_d;
			rsalt_q  <= rsalt_d;
		end
	end

	assign busy           = (state_q != sam_pkg::ST_IDLE);
	assign done           = done_q;
	assign status         = status_q;
	assign result_slot    = rslot_q;
	assign result_salt    = rsalt_q;
	assign live_total     = 11'(live_q);
	assign high_water_out = 11'(hw_q);

endmodule

`default_nettype wire

// ===== design/salted_handle_slot_allocator.sv =====
// Salted handle slot allocator. One command beat is taken at a rising edge where start is
// high and busy is low. Its single result appears in the cycle after the last busy cycle,
// or in the cycle after acceptance when the command is refused up front or needs no slot
// read. It is marked by done for exactly one cycle and must be captured then: the receiver
// cannot stall it. Slot salts live in one synchronous RAM (one read, one write port,
// registered read data), so every slot the logic touches is read and then checked. lookup,
// allocate_at and a free that does not end at the high-water mark touch one slot. allocate
// scans slots from the free hint and stops with full at the slot limit. next_live visits
// slots until a live one or the high-water mark. A free of the topmost slot also drops the
// high-water mark over the free slots below it, until it reaches a live slot or zero.
// clear sweeps the RAM, writing zero to every slot. After reset the same sweep runs with
// busy high; APB writes are taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module salted_handle_slot_allocator #(
	parameter int SLOT_DEPTH = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// APB register port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	// command side
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  opcode,
	input  wire logic [15:0] slot_index,
	input  wire logic [15:0] handle_salt,
	// result side
	output logic             done,
	output logic      [2:0]  status,
	output logic      [9:0]  result_slot,
	output logic      [15:0] result_salt,
	output logic      [10:0] live_total,
	output logic      [10:0] high_water_out
);

	localparam int AW = $clog2(SLOT_DEPTH);
	localparam int CW = $clog2(SLOT_DEPTH + 1);

	logic [10:0]   max_slots_q;
	logic [15:0]   salt_seed_q;
	logic          cfg_wr;
	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;

	// Register write on the access phase; the low address bits are don't-care.
	assign cfg_wr = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_slots_q <= sam_pkg::MAX_SLOTS_RESET;
			salt_seed_q <= 16'd0;
		end else if (cfg_wr) begin
			if (paddr[2] == sam_pkg::REG_MAX_SLOTS) max_slots_q <= pwdata[10:0];
			else salt_seed_q <= pwdata[15:0];
		end
	end

	always_comb begin
		unique case (paddr[2])
			sam_pkg::REG_MAX_SLOTS: prdata = {21'd0, max_slots_q};
			sam_pkg::REG_SALT_SEED: prdata = {16'd0, salt_seed_q};
			default:                prdata = 32'd0;
		endcase
	end

	// Sequencer: scans, checks and read-modify-write of the salt table.
	sam_engine #(
		.SLOT_DEPTH(SLOT_DEPTH),
		.AW        (AW),
		.CW        (CW)
	) u_engine (
		.clk           (clk),
		.arst_n        (arst_n),
		.max_slots     (max_slots_q),
		.salt_seed     (salt_seed_q),
		.start         (start),
		.busy          (busy),
		.opcode        (opcode),
		.slot_index    (slot_index),
		.handle_salt   (handle_salt),
		.done          (done),
		.status        (status),
		.result_slot   (result_slot),
		.result_salt   (result_salt),
		.live_total    (live_total),
		.high_water_out(high_water_out),
		.mem_we        (mem_we),
		.mem_waddr     (mem_waddr),
		.mem_wdata     (mem_wdata),
		.mem_raddr     (mem_raddr),
		.mem_rdata     (mem_rdata)
	);

	// Salt table: one salt per slot, zero marks a free slot.
	sam_slot_ram #(
		.DEPTH(SLOT_DEPTH),
		.AW   (AW)
	) u_slot_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

`default_nettype wire
